@@ rtl/b64dfr_pkg.sv @@
// ----------------------------------------------------------------------------
// b64dfr_pkg
// Shared constants, types and helper functions of the base64 filter deframer.
// ----------------------------------------------------------------------------
package b64dfr_pkg;

	localparam int FilterSlots  = 12;
	localparam int FrameLen     = 59;
	localparam int PayloadLen   = 42;
	localparam int RecordLen    = 21;
	localparam int PayloadBits  = PayloadLen * 8;
	localparam int RecordBits   = RecordLen * 8;
	localparam int CoefBits     = 160;
	localparam int JobDepth     = 2;

	localparam logic [11:0] CrcPoly = 12'h80F;
	localparam logic [7:0]  FrameId = 8'h01;
	localparam logic [7:0]  FrameTag = 8'h46;

	localparam logic [6:0] PosLastData = 7'd56;
	localparam logic [6:0] PosCrcHi    = 7'd57;
	localparam logic [6:0] PosCrcLo    = 7'd58;
	localparam logic [6:0] PosEnd      = 7'd59;
	localparam logic [6:0] PosSat      = 7'd60;

	localparam logic KindVerdict = 1'b0;
	localparam logic KindUpdate  = 1'b1;

	localparam logic RegTarget  = 1'b0;
	localparam logic RegForward = 1'b1;

	typedef struct packed {
		logic                   ok;
		logic [PayloadBits-1:0] payload;
	} frm_job_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F;
	endfunction

	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [7:0] r;
		if (c >= 8'h41 && c <= 8'h5A) r = c - 8'h41;
		else if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h61 + 8'd26;
		else if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30 + 8'd52;
		else if (c == 8'h2B) r = 8'd62;
		else r = 8'd63;
		return r[5:0];
	endfunction

	function automatic logic [11:0] crc_byte(input logic [11:0] crc, input logic [7:0] b);
		logic [11:0] x;
		x = crc ^ {b, 4'b0};
		for (int i = 0; i < 8; i++) begin
			if (x[11]) x = {x[10:0], 1'b0} ^ CrcPoly;
			else x = {x[10:0], 1'b0};
		end
		return x;
	endfunction

endpackage

@@ rtl/b64dfr_front.sv @@
// ----------------------------------------------------------------------------
// b64dfr_front
// Character parser: base64 decode, running CRC, payload capture, frame check.
// ----------------------------------------------------------------------------
module b64dfr_front import b64dfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] msg_id,
	input  logic [7:0] character,
	input  logic       first_char,
	input  logic       last_char,
	output logic       job_push,
	output frm_job_t   job,
	input  logic       job_full
);

	logic [6:0]             cnt_q;
	logic [17:0]            acc_q;
	logic [11:0]            crc_q;
	logic [11:0]            rcv_q;
	logic                   cand_q;
	logic [PayloadBits-1:0] pay_q;

	logic [6:0]  cnt_e, cnt_n;
	logic [17:0] acc_e, acc_n;
	logic [11:0] crc_e, crc_n, rcv_e, rcv_n;
	logic        cand_e, cand_n, shift_en;
	logic [5:0]  sx;
	logic [6:0]  k;
	logic [23:0] grp;
	logic        take;

	assign in_ready = !job_full;
	assign take     = in_valid && in_ready;
	assign sx       = sextet_of(character);
	assign k        = cnt_e - 7'd1;
	assign grp      = {acc_e, sx};

	always_comb begin
		cnt_e  = first_char ? 7'd0 : cnt_q;
		acc_e  = first_char ? 18'd0 : acc_q;
		crc_e  = first_char ? 12'd0 : crc_q;
		rcv_e  = first_char ? 12'd0 : rcv_q;
		cand_e = first_char ? (msg_id == FrameId) : cand_q;
		acc_n  = acc_e;
		crc_n  = crc_e;
		rcv_n  = rcv_e;
		cand_n = cand_e;
		shift_en = 1'b0;
		if (cnt_e == 7'd0) begin
			if (character != FrameTag) cand_n = 1'b0;
		end else if (cnt_e < PosEnd) begin
			if (!is_letter(character)) cand_n = 1'b0;
			if (cnt_e <= PosLastData) begin
				if (k[1:0] == 2'd3) begin
					crc_n = crc_byte(crc_byte(crc_byte(crc_e, grp[23:16]), grp[15:8]), grp[7:0]);
					acc_n = 18'd0;
					shift_en = 1'b1;
				end else begin
					acc_n = {acc_e[11:0], sx};
				end
			end else if (cnt_e == PosCrcHi) begin
				rcv_n = {sx, 6'b0};
			end else begin
				rcv_n = rcv_e | {6'b0, sx};
			end
		end else begin
			cand_n = 1'b0;
		end
		cnt_n = (cnt_e < PosSat) ? cnt_e + 7'd1 : cnt_e;
	end

	assign job_push    = take && last_char;
	assign job.ok      = cand_n && (cnt_e == PosCrcLo) && (rcv_n == crc_n);
	assign job.payload = pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			acc_q  <= '0;
			crc_q  <= '0;
			rcv_q  <= '0;
			cand_q <= 1'b0;
		end else if (take) begin
			if (last_char) begin
				cnt_q  <= '0;
				acc_q  <= '0;
				crc_q  <= '0;
				rcv_q  <= '0;
				cand_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_n;
				acc_q  <= acc_n;
				crc_q  <= crc_n;
				rcv_q  <= rcv_n;
				cand_q <= cand_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && shift_en) pay_q <= {pay_q[PayloadBits-25:0], grp};
	end

endmodule

@@ rtl/b64dfr_fifo.sv @@
// ----------------------------------------------------------------------------
// b64dfr_fifo
// Short job queue between parser and table update.
// ----------------------------------------------------------------------------
module b64dfr_fifo import b64dfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  frm_job_t wdata,
	output logic     full,
	input  logic     pop,
	output logic     valid,
	output frm_job_t rdata
);

	frm_job_t mem_q [JobDepth];
	logic     wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'(JobDepth);
	assign valid = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ rtl/b64dfr_back.sv @@
// ----------------------------------------------------------------------------
// b64dfr_back
// Table update and result emission: the two records of a valid frame, then the verdict.
// ----------------------------------------------------------------------------
module b64dfr_back import b64dfr_pkg::*; #(
	parameter int FILTER_SLOTS = FilterSlots
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          target_en,
	input  logic          forward_en,
	input  logic          job_valid,
	input  frm_job_t      job,
	output logic          job_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          out_kind,
	output logic          out_consumed,
	output logic          out_forward,
	output logic [3:0]    out_index,
	output logic [CoefBits-1:0] out_coef,
	output logic          out_last
);

	localparam int IW = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;

	typedef enum logic [2:0] {
		PH_REC0 = 3'b001,
		PH_REC1 = 3'b010,
		PH_VERD = 3'b100
	} phase_t;

	phase_t phase_q;
	logic [CoefBits-1:0] tbl_q [FILTER_SLOTS];

	logic                  can_load, step, in_rng, changed, emit_upd, emit_verd;
	logic [RecordBits-1:0] rec;
	logic [7:0]            idx;
	logic [CoefBits-1:0]   coefs;

	assign can_load = !out_valid || out_ready;
	assign step     = can_load && job_valid;
	assign rec      = (phase_q == PH_REC0) ? job.payload[PayloadBits-1 -: RecordBits]
	                                       : job.payload[RecordBits-1:0];
	assign idx      = rec[RecordBits-1 -: 8];
	assign coefs    = rec[CoefBits-1:0];
	assign in_rng   = {1'b0, idx} < 9'(FILTER_SLOTS);
	assign changed  = in_rng && (tbl_q[idx[IW-1:0]] != coefs);
	assign emit_verd = step && (phase_q == PH_VERD || (phase_q == PH_REC0 && !job.ok));
	assign emit_upd  = step && !emit_verd && changed && target_en;
	assign job_pop   = emit_verd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_REC0;
			out_valid <= 1'b0;
			for (int i = 0; i < FILTER_SLOTS; i++) tbl_q[i] <= '0;
		end else begin
			if (can_load) out_valid <= emit_verd || emit_upd;
			if (step) begin
				unique case (phase_q)
					PH_REC0: begin
						if (job.ok) phase_q <= PH_REC1;
					end
					PH_REC1: phase_q <= PH_VERD;
					PH_VERD: phase_q <= PH_REC0;
					default: phase_q <= PH_REC0;
				endcase
				if (!emit_verd && changed) tbl_q[idx[IW-1:0]] <= coefs;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			out_kind     <= emit_verd ? KindVerdict : KindUpdate;
			out_consumed <= emit_verd && job.ok;
			out_forward  <= emit_verd && !job.ok && forward_en;
			out_index    <= emit_verd ? 4'd0 : idx[3:0];
			out_coef     <= emit_verd ? '0 : coefs;
			out_last     <= emit_verd;
		end
	end

endmodule

@@ rtl/base64_crc12_filter_update_deframer_top.sv @@
// ----------------------------------------------------------------------------
// base64_crc12_filter_update_deframer_top
// Deframer for base64 filter-update frames carried in metadata text.
//
// Input stream: one character per beat; tdata = msg_id, character;
// tuser marks the first character, tlast the final one. A beat is taken in
// every cycle while the job queue has room.
// Output stream: per message zero to two filter updates (tuser = 1) and then
// one verdict (tuser = 0, tlast = 1).
// The back end steps through each record of a valid frame and then the verdict
// (only the verdict for a rejected message); a two-entry job queue absorbs
// bursts of short messages.
// Reset clears the parser state (but not its payload register), the queue
// pointers, the output valid flag, the control registers and the whole
// filter table at once.
// A stalled receiver holds the output register; the queue fills and then
// input tready drops.
// ----------------------------------------------------------------------------
module base64_crc12_filter_update_deframer_top import b64dfr_pkg::*; #(
	parameter int FILTER_SLOTS = FilterSlots
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,  // msg_id[7:0], character[15:8]
	input  logic         s_tuser,  // first_char
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [167:0] m_tdata,  // consumed, forward, filter_index, b0, b1, b2, a1, a2
	output logic         m_tuser,  // kind
	output logic         m_tlast
);

	logic     target_q, forward_q, wr;
	logic     job_push, job_full, job_pop, job_valid;
	frm_job_t job_in, job_out;
	logic     o_kind, o_cons, o_fwd, o_last;
	logic [3:0] o_idx;
	logic [CoefBits-1:0] o_coef;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign prdata = {31'b0, (paddr[2] == RegForward) ? forward_q : target_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= 1'b0;
			forward_q <= 1'b0;
		end else if (wr) begin
			if (paddr[2] == RegTarget) target_q <= pwdata[0];
			else forward_q <= pwdata[0];
		end
	end

	b64dfr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.msg_id(s_tdata[7:0]), .character(s_tdata[15:8]),
		.first_char(s_tuser), .last_char(s_tlast),
		.job_push(job_push), .job(job_in), .job_full(job_full)
	);

	b64dfr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(job_push), .wdata(job_in), .full(job_full),
		.pop(job_pop), .valid(job_valid), .rdata(job_out)
	);

	b64dfr_back #(.FILTER_SLOTS(FILTER_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.target_en(target_q), .forward_en(forward_q),
		.job_valid(job_valid), .job(job_out), .job_pop(job_pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_kind(o_kind), .out_consumed(o_cons), .out_forward(o_fwd),
		.out_index(o_idx), .out_coef(o_coef), .out_last(o_last)
	);

	assign m_tdata = {2'b0, o_coef[31:0], o_coef[63:32], o_coef[95:64], o_coef[127:96],
		o_coef[159:128], o_idx, o_fwd, o_cons};
	assign m_tuser = o_kind;
	assign m_tlast = o_last;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 CRC-12 filter-update deframer.
// Drives metadata characters as stream beats and writes both control
// registers over APB between phases. A predictor models the parser, the CRC,
// the filter table and the verdicts, and each output beat is checked against
// the oldest expected result. A directed table covers the special messages,
// then random valid frames, broken frames and junk messages run under
// changing handshake pressure.
// ----------------------------------------------------------------------------
module tb_top;
	import b64dfr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 4000;
	localparam int HoldCycles = 300;
	localparam logic [2:0] AddrTarget  = 3'(4 * int'(RegTarget));
	localparam logic [2:0] AddrForward = 3'(4 * int'(RegForward));

	typedef enum int {M_OK, M_BADCRC, M_BADLETTER, M_NOF, M_NOFIRST, M_LONG, M_SHORT,
		M_ONE} msg_mode_t;

	typedef struct {
		logic [7:0] id;
		logic [7:0] ch;
		logic       first;
		logic       last;
	} char_beat_t;

	typedef struct packed {
		logic             kind;
		logic             consumed;
		logic             forward;
		logic [3:0]       idx;
		logic [4:0][31:0] coef;
		logic             last;
	} filt_result_t;

	typedef struct {
		msg_mode_t   mode;
		logic [7:0]  id;
		logic [7:0]  i0;
		logic [7:0]  i1;
		logic [31:0] w0;
		logic [31:0] w1;
		int          typed;
	} dir_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata = '0;  // msg_id[7:0], character[15:8]
	logic         s_tuser = 1'b0;  // first_char
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [167:0] m_tdata;  // consumed, forward, filter_index, b0, b1, b2, a1, a2
	logic         m_tuser;  // kind
	logic         m_tlast;

	base64_crc12_filter_update_deframer_top u_dut (.*);

	char_beat_t   char_q[$];
	filt_result_t result_q[$];
	int           typed_q[$];
	int           err_cnt = 0;
	int           send_idle = 0;
	int           recv_idle = 0;
	logic         hold = 1'b0;
	logic         pressure_go = 1'b0;
	int           stall_cnt = 0;

	// predictor state
	int               pos_cnt;
	logic [17:0]      sext_acc;
	logic [11:0]      crc_run;
	logic [11:0]      crc_got;
	logic             cand;
	logic [7:0]       pay[PayloadLen];
	logic [4:0][31:0] ftable[FilterSlots];
	logic             tgt_en = 1'b0;
	logic             fwd_en = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [11:0] crc_step(input logic [11:0] crc, input logic [7:0] b);
		logic [11:0] x;
		x = crc ^ {b, 4'h0};
		for (int i = 0; i < 8; i++) begin
			x = x[11] ? ({x[10:0], 1'b0} ^ CrcPoly) : {x[10:0], 1'b0};
		end
		return x;
	endfunction

	// returns {not_a_letter, sextet}
	function automatic logic [6:0] decode_char(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
		if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 26)};
		if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 52)};
		if (c == "+") return {1'b0, 6'd62};
		if (c == "/") return {1'b0, 6'd63};
		return {1'b1, 6'd63};
	endfunction

	function automatic logic [7:0] encode_sextet(input logic [5:0] s);
		if (s < 26) return 8'("A" + s);
		if (s < 52) return 8'("a" + s - 26);
		if (s < 62) return 8'("0" + s - 52);
		return (s == 62) ? 8'("+") : 8'("/");
	endfunction

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(7))
			0: return 32'h0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0][31:0] fill_coefs(input logic [31:0] w);
		logic [4:0][31:0] c;
		for (int k = 0; k < 5; k++) c[k] = k[0] ? ~w : w;
		return c;
	endfunction

	function automatic void clear_parser();
		pos_cnt = 0;
		sext_acc = '0;
		crc_run = '0;
		crc_got = '0;
		cand = 1'b0;
	endfunction

	function automatic void take_byte(input int b, input logic [7:0] v);
		pay[b] = v;
		crc_run = crc_step(crc_run, v);
	endfunction

	function automatic void apply_record(input int off);
		logic [4:0][31:0] nxt;
		filt_result_t     r;
		int               idx;
		idx = pay[off];
		for (int k = 0; k < 5; k++) begin
			nxt[k] = {pay[off+1+4*k], pay[off+2+4*k], pay[off+3+4*k], pay[off+4+4*k]};
		end
		if (idx >= FilterSlots || ftable[idx] == nxt) return;
		ftable[idx] = nxt;
		if (!tgt_en) return;
		r = '0;
		r.kind = KindUpdate;
		r.idx = 4'(idx);
		r.coef = nxt;
		result_q.push_back(r);
	endfunction

	function automatic void predict_char(input char_beat_t bt);
		int           pos;
		int           k;
		logic [6:0]   d;
		logic [23:0]  v;
		logic         ok;
		int           typed;
		filt_result_t r;
		if (bt.first) begin
			clear_parser();
			cand = (bt.id == FrameId);
		end
		pos = pos_cnt;
		d = decode_char(bt.ch);
		if (pos == 0) begin
			if (bt.ch != FrameTag) cand = 1'b0;
		end else if (pos < FrameLen) begin
			if (d[6]) cand = 1'b0;
			if (pos <= 56) begin
				k = pos - 1;
				if (k % 4 == 3) begin
					v = {sext_acc, d[5:0]};
					take_byte((k / 4) * 3, v[23:16]);
					take_byte((k / 4) * 3 + 1, v[15:8]);
					take_byte((k / 4) * 3 + 2, v[7:0]);
					sext_acc = '0;
				end else begin
					sext_acc = {sext_acc[11:0], d[5:0]};
				end
			end else if (pos == 57) begin
				crc_got = {d[5:0], 6'h0};
			end else begin
				crc_got[5:0] = d[5:0];
			end
		end else begin
			cand = 1'b0;
		end
		if (pos_cnt < 60) pos_cnt++;
		if (bt.last) begin
			ok = cand && pos == FrameLen - 1 && crc_got == crc_run;
			if (ok) begin
				apply_record(0);
				apply_record(RecordLen);
			end
			typed = typed_q.size() ? typed_q.pop_front() : -1;
			if (typed >= 0 && typed != int'(ok)) begin
				$error("consumed: expected %0d, predicted %0d", typed, ok);
				err_cnt++;
			end
			r = '0;
			r.kind = KindVerdict;
			r.consumed = ok;
			r.forward = !ok && fwd_en;
			r.last = 1'b1;
			result_q.push_back(r);
			clear_parser();
		end
	endfunction

	function automatic void check_field(input string name, input logic [63:0] e,
		input logic [63:0] g);
		if (e !== g) begin
			$error("%s: expected %0h, got %0h", name, e, g);
			err_cnt++;
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (!s_tvalid || s_tready) begin
			if (char_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				char_beat_t bt;
				bt = char_q.pop_front();
				s_tdata <= {bt.ch, bt.id};
				s_tuser <= bt.first;
				s_tlast <= bt.last;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		m_tready <= !hold && ($urandom_range(99) >= recv_idle);
	end

	initial begin
		wait (pressure_go);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold <= 1'b0;
	end

	// predict on accepted input, check accepted output
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				char_beat_t bt;
				bt.id = s_tdata[7:0];
				bt.ch = s_tdata[15:8];
				bt.first = s_tuser;
				bt.last = s_tlast;
				predict_char(bt);
			end
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result beat: tuser %0b tdata %0h", m_tuser, m_tdata);
					err_cnt++;
				end else begin
					filt_result_t e;
					e = result_q.pop_front();
					check_field("kind", e.kind, m_tuser);
					check_field("consumed", e.consumed, m_tdata[0]);
					check_field("forward", e.forward, m_tdata[1]);
					check_field("filter_index", e.idx, m_tdata[5:2]);
					check_field("coef_b0", e.coef[0], m_tdata[37:6]);
					check_field("coef_b1", e.coef[1], m_tdata[69:38]);
					check_field("coef_b2", e.coef[2], m_tdata[101:70]);
					check_field("coef_a1", e.coef[3], m_tdata[133:102]);
					check_field("coef_a2", e.coef[4], m_tdata[165:134]);
					check_field("last", e.last, m_tlast);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= StallLimit) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (char_q.size() > 0 || s_tvalid || result_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(input logic t, input logic f);
		reg_write(AddrTarget, {31'h0, t});
		reg_write(AddrForward, {31'h0, f});
		tgt_en = t;
		fwd_en = f;
	endtask

	task automatic push_chars(input logic [7:0] id, input logic [7:0] chars[$],
		input logic with_first);
		char_beat_t bt;
		foreach (chars[i]) begin
			bt.id = id;
			bt.ch = chars[i];
			bt.first = (i == 0) && with_first;
			bt.last = (i == chars.size() - 1);
			char_q.push_back(bt);
		end
	endtask

	task automatic push_frame(input msg_mode_t mode, input logic [7:0] id,
		input logic [7:0] i0, input logic [4:0][31:0] c0,
		input logic [7:0] i1, input logic [4:0][31:0] c1, input int typed);
		logic [7:0]  p[PayloadLen];
		logic [7:0]  chars[$];
		logic [11:0] crc;
		logic [23:0] v;
		p[0] = i0;
		p[RecordLen] = i1;
		for (int k = 0; k < 5; k++) begin
			for (int j = 0; j < 4; j++) begin
				p[1+4*k+j] = c0[k][31-8*j -: 8];
				p[RecordLen+1+4*k+j] = c1[k][31-8*j -: 8];
			end
		end
		crc = '0;
		foreach (p[i]) crc = crc_step(crc, p[i]);
		if (mode == M_BADCRC) crc ^= 12'(1 << $urandom_range(11));
		chars.push_back((mode == M_NOF) ? 8'("G") : FrameTag);
		for (int g = 0; g < 14; g++) begin
			v = {p[3*g], p[3*g+1], p[3*g+2]};
			for (int j = 0; j < 4; j++) chars.push_back(encode_sextet(v[23-6*j -: 6]));
		end
		chars.push_back(encode_sextet(crc[11:6]));
		chars.push_back(encode_sextet(crc[5:0]));
		if (mode == M_BADLETTER) chars[$urandom_range(1, 58)] = 8'("=");
		if (mode == M_SHORT) void'(chars.pop_back());
		if (mode == M_LONG) begin
			repeat ($urandom_range(1, 4))
				chars.push_back(encode_sextet(6'($urandom_range(63))));
		end
		typed_q.push_back(typed);
		push_chars(id, chars, mode != M_NOFIRST);
	endtask

	task automatic push_junk();
		logic [7:0] chars[$];
		char_beat_t bt;
		int         n;
		n = $urandom_range(1, 70);
		for (int i = 0; i < n; i++) begin
			bt.id = 8'($urandom_range(255));
			bt.ch = $urandom_range(1) ? 8'($urandom_range(255)) :
				encode_sextet(6'($urandom_range(63)));
			bt.first = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(19) == 0);
			bt.last = (i == n - 1);
			char_q.push_back(bt);
		end
		typed_q.push_back(-1);
	endtask

	task automatic push_random_msg();
		logic [7:0]       i0, i1;
		logic [4:0][31:0] c0, c1;
		int               r;
		i0 = ($urandom_range(99) < 85) ? 8'($urandom_range(FilterSlots - 1)) :
			8'($urandom_range(FilterSlots, 255));
		i1 = ($urandom_range(99) < 85) ? 8'($urandom_range(FilterSlots - 1)) :
			8'($urandom_range(FilterSlots, 255));
		for (int k = 0; k < 5; k++) begin
			c0[k] = rnd_word();
			c1[k] = rnd_word();
		end
		if (i0 < FilterSlots && $urandom_range(5) == 0) c0 = ftable[i0];
		r = $urandom_range(99);
		if (r < 60) push_frame(M_OK, FrameId, i0, c0, i1, c1, -1);
		else if (r < 67) push_frame(M_BADCRC, FrameId, i0, c0, i1, c1, -1);
		else if (r < 72) push_frame(M_OK, 8'($urandom_range(2, 255)), i0, c0, i1, c1, -1);
		else if (r < 77) push_frame(M_BADLETTER, FrameId, i0, c0, i1, c1, -1);
		else if (r < 80) push_frame(M_LONG, FrameId, i0, c0, i1, c1, -1);
		else push_junk();
	endtask

	initial begin
		dir_row_t         rows[$];
		logic [7:0]       one_char[$];
		int               phase_send[4] = '{29, 73, 0, 0};
		int               phase_recv[4] = '{73, 29, 0, 0};
		logic             phase_tgt[4] = '{1'b1, 1'b0, 1'b0, 1'b1};
		logic             phase_fwd[4] = '{1'b0, 1'b1, 1'b0, 1'b1};

		foreach (pay[i]) pay[i] = '0;
		foreach (ftable[i]) ftable[i] = '0;
		clear_parser();

		rows = '{
			'{M_OK,        FrameId, 8'd0,   8'd11,  32'h7FFF_FFFF, 32'h8000_0000, 1},
			'{M_OK,        FrameId, 8'd0,   8'd11,  32'h7FFF_FFFF, 32'h8000_0000, 1},
			'{M_OK,        FrameId, 8'd12,  8'd255, 32'h1234_5678, 32'hFFFF_FFFF, 1},
			'{M_OK,        FrameId, 8'd5,   8'd5,   32'h0000_0001, 32'hDEAD_BEEF, 1},
			'{M_OK,        FrameId, 8'd1,   8'd2,   32'h0,         32'h0,         1},
			'{M_BADCRC,    FrameId, 8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 0},
			'{M_OK,        8'd0,    8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 0},
			'{M_OK,        8'hFF,   8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 0},
			'{M_BADLETTER, FrameId, 8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 0},
			'{M_NOF,       FrameId, 8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 0},
			'{M_NOFIRST,   FrameId, 8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 0},
			'{M_LONG,      FrameId, 8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 0},
			'{M_SHORT,     FrameId, 8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 0},
			'{M_ONE,       FrameId, 8'd0,   8'd0,   32'h0,         32'h0,         0},
			'{M_OK,        FrameId, 8'd3,   8'd4,   32'h1111_1111, 32'h2222_2222, 1}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: no update beats, no forwarding
		typed_q.push_back(0);
		push_chars(FrameId, '{8'h0}, 1'b1);
		push_frame(M_OK, FrameId, 8'd7, fill_coefs(32'h5555_AAAA), 8'd8,
			fill_coefs(32'h0F0F_F0F0), 1);
		drain();
		set_regs(1'b1, 1'b1);

		foreach (rows[i]) begin
			if (rows[i].mode == M_ONE) begin
				one_char = '{FrameTag};
				typed_q.push_back(rows[i].typed);
				push_chars(rows[i].id, one_char, 1'b1);
			end else begin
				push_frame(rows[i].mode, rows[i].id, rows[i].i0, fill_coefs(rows[i].w0),
					rows[i].i1, fill_coefs(rows[i].w1), rows[i].typed);
			end
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			set_regs(phase_tgt[ph], phase_fwd[ph]);
			send_idle = phase_send[ph];
			recv_idle = phase_recv[ph];
			repeat (12) push_random_msg();
			if (ph == 3) pressure_go = 1'b1;
			drain();
		end

		repeat (20) @(posedge clk);
		if (err_cnt == 0 && result_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
